FILE: rtl/core/rsi_pkg.sv
// Shared widths, types and register codes for the ray and segment intersection core.
package rsi_pkg;

    localparam int COORD_W  = 32;
    localparam int DIR_W    = 16;
    localparam int DIR_FRAC = 14;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SP_W     = DIR_W + DIFF_W;
    localparam int DP_W     = 2 * DIFF_W;
    localparam int DEN_W    = 48;
    localparam int QUO_W    = 33;
    localparam int HALF_W   = 24;
    localparam int PP_W     = HALF_W + COORD_W;
    localparam int NUM_W    = DEN_W + COORD_W;
    localparam int KMAG_W   = 65;

    typedef enum logic [1:0] {
        CFG_SEG_START_X = 2'd0,
        CFG_SEG_START_Y = 2'd1,
        CFG_SEG_END_X   = 2'd2,
        CFG_SEG_END_Y   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                      miss;
        logic                      kovf;
        logic                      ex_neg;
        logic                      ey_neg;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
    } side_t;

endpackage

FILE: rtl/core/rsi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rsi_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rsi_pkg::DEN_W-1:0]  rem_in,
    input  logic [rsi_pkg::QUO_W-1:0]  num_in,
    input  logic [rsi_pkg::DEN_W-1:0]  den_in,
    output logic [rsi_pkg::QUO_W-1:0]  quot
);

    logic [rsi_pkg::DEN_W-1:0] rem_reg  [rsi_pkg::QUO_W];
    logic [rsi_pkg::QUO_W-1:0] num_reg  [rsi_pkg::QUO_W];
    logic [rsi_pkg::DEN_W-1:0] den_reg  [rsi_pkg::QUO_W];
    logic [rsi_pkg::QUO_W-1:0] quo_reg  [rsi_pkg::QUO_W];
    logic [rsi_pkg::DEN_W-1:0] rem_next [rsi_pkg::QUO_W];
    logic [rsi_pkg::QUO_W-1:0] num_next [rsi_pkg::QUO_W];
    logic [rsi_pkg::DEN_W-1:0] den_next [rsi_pkg::QUO_W];
    logic [rsi_pkg::QUO_W-1:0] quo_next [rsi_pkg::QUO_W];

    always_comb
    begin
        logic [rsi_pkg::DEN_W-1:0] r;
        logic [rsi_pkg::QUO_W-1:0] n;
        logic [rsi_pkg::DEN_W-1:0] d;
        logic [rsi_pkg::QUO_W-1:0] q;
        logic [rsi_pkg::DEN_W:0]   t;
        for (int i = 0; i < rsi_pkg::QUO_W; i++)
        begin
            if (i == 0)
            begin
                r = rem_in;
                n = num_in;
                d = den_in;
                q = '0;
            end
            else
            begin
                r = rem_reg[i-1];
                n = num_reg[i-1];
                d = den_reg[i-1];
                q = quo_reg[i-1];
            end
            t = {r, n[rsi_pkg::QUO_W-1]};
            if (t >= {1'b0, d})
            begin
                rem_next[i] = rsi_pkg::DEN_W'(t - {1'b0, d});
                quo_next[i] = {q[rsi_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = t[rsi_pkg::DEN_W-1:0];
                quo_next[i] = {q[rsi_pkg::QUO_W-2:0], 1'b0};
            end
            num_next[i] = {n[rsi_pkg::QUO_W-2:0], 1'b0};
            den_next[i] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < rsi_pkg::QUO_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                num_reg[i] <= num_next[i];
                den_reg[i] <= den_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign quot = quo_reg[rsi_pkg::QUO_W-1];

endmodule

FILE: rtl/core/ray_segment_intersect_core.sv
// Top level: 2D ray against a configured line segment, fully pipelined.
// Stages from input transfer to result valid: six arithmetic stages,
// 33 divider stages set by the quotient width, and one output register.
// Throughput: one ray per cycle; the whole pipeline holds while a result is stalled.
// Reset: rst_n clears all valid bits and the segment registers to zero.
// Configuration writes are taken every cycle.
module ray_segment_intersect_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [rsi_pkg::COORD_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [rsi_pkg::COORD_W-1:0] origin_x,
    input  logic signed [rsi_pkg::COORD_W-1:0] origin_y,
    input  logic signed [rsi_pkg::DIR_W-1:0]  dir_cos,
    input  logic signed [rsi_pkg::DIR_W-1:0]  dir_sin,
    input  logic                              from_this_segment,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic signed [rsi_pkg::COORD_W-1:0] hit_x,
    output logic signed [rsi_pkg::COORD_W-1:0] hit_y,
    output logic [rsi_pkg::COORD_W-1:0]       distance
);

    localparam int CW = rsi_pkg::COORD_W;
    localparam int XW = rsi_pkg::DIFF_W;
    localparam int NS = rsi_pkg::QUO_W;

    logic signed [CW-1:0] sx_reg, sy_reg, ex_pt_reg, ey_pt_reg;
    logic en;

    assign cfg_ready = 1'b1;
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg    <= '0;
            sy_reg    <= '0;
            ex_pt_reg <= '0;
            ey_pt_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (rsi_pkg::cfg_idx_t'(cfg_index))
                rsi_pkg::CFG_SEG_START_X: sx_reg    <= cfg_data;
                rsi_pkg::CFG_SEG_START_Y: sy_reg    <= cfg_data;
                rsi_pkg::CFG_SEG_END_X:   ex_pt_reg <= cfg_data;
                rsi_pkg::CFG_SEG_END_Y:   ey_pt_reg <= cfg_data;
                default:                  sx_reg    <= sx_reg;
            endcase
        end
    end

    logic [5:0] v_reg;
    logic [NS-1:0] dv_reg;
    rsi_pkg::side_t side_reg [6];
    rsi_pkg::side_t dside_reg [NS];

    // stage 1: differences
    logic signed [XW-1:0] dx1_reg, dy1_reg, ex1_reg, ey1_reg;
    logic signed [rsi_pkg::DIR_W-1:0] c1_reg, s1_reg;
    logic signed [XW-1:0] ex_next, ey_next;
    rsi_pkg::side_t side1_next;

    always_comb
    begin
        ex_next = XW'(ex_pt_reg) - XW'(sx_reg);
        ey_next = XW'(ey_pt_reg) - XW'(sy_reg);
        side1_next.miss    = from_this_segment;
        side1_next.kovf    = 1'b0;
        side1_next.ex_neg  = ex_next[XW-1];
        side1_next.ey_neg  = ey_next[XW-1];
        side1_next.start_x = sx_reg;
        side1_next.start_y = sy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg     <= XW'(origin_x) - XW'(sx_reg);
            dy1_reg     <= XW'(origin_y) - XW'(sy_reg);
            ex1_reg     <= ex_next;
            ey1_reg     <= ey_next;
            c1_reg      <= dir_cos;
            s1_reg      <= dir_sin;
            side_reg[0] <= side1_next;
        end
    end

    // stage 2: products
    logic signed [rsi_pkg::SP_W-1:0] se2_reg, ce2_reg, sd2_reg, cd2_reg;
    logic signed [rsi_pkg::DP_W-1:0] de2_reg, ed2_reg;
    logic [CW-1:0] exm2_reg, eym2_reg;
    logic signed [XW-1:0] exn, eyn;

    assign exn = -ex1_reg;
    assign eyn = -ey1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            se2_reg     <= rsi_pkg::SP_W'(s1_reg) * rsi_pkg::SP_W'(ex1_reg);
            ce2_reg     <= rsi_pkg::SP_W'(c1_reg) * rsi_pkg::SP_W'(ey1_reg);
            sd2_reg     <= rsi_pkg::SP_W'(s1_reg) * rsi_pkg::SP_W'(dx1_reg);
            cd2_reg     <= rsi_pkg::SP_W'(c1_reg) * rsi_pkg::SP_W'(dy1_reg);
            de2_reg     <= rsi_pkg::DP_W'(dx1_reg) * rsi_pkg::DP_W'(ey1_reg);
            ed2_reg     <= rsi_pkg::DP_W'(ex1_reg) * rsi_pkg::DP_W'(dy1_reg);
            exm2_reg    <= ex1_reg[XW-1] ? exn[CW-1:0] : ex1_reg[CW-1:0];
            eym2_reg    <= ey1_reg[XW-1] ? eyn[CW-1:0] : ey1_reg[CW-1:0];
            side_reg[1] <= side_reg[0];
        end
    end

    // stage 3: cross products
    logic signed [rsi_pkg::SP_W:0] den3_reg, tn3_reg;
    logic signed [rsi_pkg::DP_W:0] kn3_reg;
    logic [CW-1:0] exm3_reg, eym3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den3_reg    <= (rsi_pkg::SP_W+1)'(se2_reg) - (rsi_pkg::SP_W+1)'(ce2_reg);
            tn3_reg     <= (rsi_pkg::SP_W+1)'(sd2_reg) - (rsi_pkg::SP_W+1)'(cd2_reg);
            kn3_reg     <= (rsi_pkg::DP_W+1)'(de2_reg) - (rsi_pkg::DP_W+1)'(ed2_reg);
            exm3_reg    <= exm2_reg;
            eym3_reg    <= eym2_reg;
            side_reg[2] <= side_reg[1];
        end
    end

    // stage 4: sign normalize
    logic signed [rsi_pkg::SP_W:0] den4_reg, tn4_reg;
    logic signed [rsi_pkg::DP_W:0] kn4_reg;
    logic [CW-1:0] exm4_reg, eym4_reg;
    logic dz4_reg;
    logic dneg;

    assign dneg = den3_reg[rsi_pkg::SP_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den4_reg    <= dneg ? -den3_reg : den3_reg;
            tn4_reg     <= dneg ? -tn3_reg : tn3_reg;
            kn4_reg     <= dneg ? -kn3_reg : kn3_reg;
            dz4_reg     <= (den3_reg == '0);
            exm4_reg    <= exm3_reg;
            eym4_reg    <= eym3_reg;
            side_reg[3] <= side_reg[2];
        end
    end

    // stage 5: range checks, partial products
    logic [rsi_pkg::DEN_W-1:0] den5_reg;
    logic [rsi_pkg::KMAG_W-1:0] kn5_reg;
    logic [rsi_pkg::PP_W-1:0] pxh5_reg, pxl5_reg, pyh5_reg, pyl5_reg;
    logic [rsi_pkg::HALF_W-1:0] tnh, tnl;
    rsi_pkg::side_t side5_next;

    assign tnh = tn4_reg[2*rsi_pkg::HALF_W-1:rsi_pkg::HALF_W];
    assign tnl = tn4_reg[rsi_pkg::HALF_W-1:0];

    always_comb
    begin
        side5_next      = side_reg[3];
        side5_next.miss = side_reg[3].miss || dz4_reg || kn4_reg[rsi_pkg::DP_W]
                          || tn4_reg[rsi_pkg::SP_W] || (tn4_reg > den4_reg);
        side5_next.kovf = ({2'b00, kn4_reg[rsi_pkg::KMAG_W-1:NS-rsi_pkg::DIR_FRAC]}
                           >= den4_reg[rsi_pkg::DEN_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den5_reg    <= den4_reg[rsi_pkg::DEN_W-1:0];
            kn5_reg     <= kn4_reg[rsi_pkg::KMAG_W-1:0];
            pxh5_reg    <= rsi_pkg::PP_W'(tnh) * rsi_pkg::PP_W'(exm4_reg);
            pxl5_reg    <= rsi_pkg::PP_W'(tnl) * rsi_pkg::PP_W'(exm4_reg);
            pyh5_reg    <= rsi_pkg::PP_W'(tnh) * rsi_pkg::PP_W'(eym4_reg);
            pyl5_reg    <= rsi_pkg::PP_W'(tnl) * rsi_pkg::PP_W'(eym4_reg);
            side_reg[4] <= side5_next;
        end
    end

    // stage 6: full products
    logic [rsi_pkg::DEN_W-1:0] den6_reg;
    logic [rsi_pkg::KMAG_W-1:0] kn6_reg;
    logic [rsi_pkg::NUM_W-1:0] px6_reg, py6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den6_reg    <= den5_reg;
            kn6_reg     <= kn5_reg;
            px6_reg     <= {pxh5_reg, {rsi_pkg::HALF_W{1'b0}}}
                           + rsi_pkg::NUM_W'(pxl5_reg);
            py6_reg     <= {pyh5_reg, {rsi_pkg::HALF_W{1'b0}}}
                           + rsi_pkg::NUM_W'(pyl5_reg);
            side_reg[5] <= side_reg[4];
        end
    end

    // dividers
    logic [NS-1:0] qk, qx, qy;

    rsi_div u_div_k (
        .clk    (clk),
        .en     (en),
        .rem_in ({2'b00, kn6_reg[rsi_pkg::KMAG_W-1:NS-rsi_pkg::DIR_FRAC]}),
        .num_in ({kn6_reg[NS-rsi_pkg::DIR_FRAC-1:0], {rsi_pkg::DIR_FRAC{1'b0}}}),
        .den_in (den6_reg),
        .quot   (qk)
    );

    rsi_div u_div_x (
        .clk    (clk),
        .en     (en),
        .rem_in ({1'b0, px6_reg[rsi_pkg::NUM_W-1:NS]}),
        .num_in (px6_reg[NS-1:0]),
        .den_in (den6_reg),
        .quot   (qx)
    );

    rsi_div u_div_y (
        .clk    (clk),
        .en     (en),
        .rem_in ({1'b0, py6_reg[rsi_pkg::NUM_W-1:NS]}),
        .num_in (py6_reg[NS-1:0]),
        .den_in (den6_reg),
        .quot   (qy)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dside_reg[0] <= side_reg[5];
            for (int i = 1; i < NS; i++)
            begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            dv_reg <= '0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[4:0], in_valid};
            dv_reg <= {dv_reg[NS-2:0], v_reg[5]};
        end
    end

    // output register
    rsi_pkg::side_t fs;
    logic hit_next;
    logic [CW-1:0] hx_next, hy_next, dist_next;

    assign fs = dside_reg[NS-1];

    always_comb
    begin
        hit_next  = !fs.miss;
        hx_next   = fs.start_x + (fs.ex_neg ? -qx[CW-1:0] : qx[CW-1:0]);
        hy_next   = fs.start_y + (fs.ey_neg ? -qy[CW-1:0] : qy[CW-1:0]);
        dist_next = (fs.kovf || qk[NS-1]) ? {CW{1'b1}} : qk[CW-1:0];
        if (fs.miss)
        begin
            hx_next   = '0;
            hy_next   = '0;
            dist_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= dv_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit      <= hit_next;
            hit_x    <= hx_next;
            hit_y    <= hy_next;
            distance <= dist_next;
        end
    end

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_x == '0 && hit_y == '0 && distance == '0)
        else $error("miss result carries nonzero payload");

    a_hold_valids: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(v_reg) && $stable(dv_reg))
        else $error("pipeline advanced during output stall");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && in_valid |=> $stable(v_reg[0]))
        else $error("input transfer taken while pipeline held");
`endif

endmodule
